// File: design/rcpv_pkg.sv
`timescale 1ns / 1ps
package rcpv_pkg;

	// coordinate width, Q15.8 by default; the fraction point takes no part in the maths
	localparam int CW = 24;
	// root and quotient width: a hit keeps both below 2^(CW-1)
	localparam int RW = CW - 1;

	typedef struct packed {
		logic signed [CW-1:0] rect_left;
		logic signed [CW-1:0] rect_top;
		logic [CW-2:0]        rect_width;
		logic [CW-2:0]        rect_height;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic [CW-2:0]        radius;
		logic                 circle_first;
	} in_word_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] push_x;
		logic signed [CW-1:0] push_y;
	} out_word_t;

	// decision bits and the inside-case push that ride along the pipe
	typedef struct packed {
		logic                 hit;
		logic                 in_rect;
		logic                 flip;
		logic                 negx;
		logic                 negy;
		logic signed [CW+1:0] px_i;
		logic signed [CW+1:0] py_i;
	} side_t;

	// operands kept through the root stages
	typedef struct packed {
		logic [RW-1:0] r;
		logic [RW-1:0] ax;
		logic [RW-1:0] ay;
	} opnd_t;

endpackage

// File: design/rect_circle_penetration_vector_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake           | word
// in      | into unit | in_valid / in_stall   | in_data  (rcpv_pkg::in_word_t)
// out     | from unit | out_valid / out_stall | out_data (rcpv_pkg::out_word_t)
//
// one word enters per cycle while out_stall does not hold the pipe; the pipe's depth is set by the
// bit-per-stage square root and the bit-per-stage dividers.
// arst_n clears every valid bit; data registers are not reset.
// a stalled output word freezes the whole pipe, so in_stall follows it in the same cycle.
module rect_circle_penetration_vector_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rcpv_pkg::in_word_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rcpv_pkg::out_word_t out_data
);
	import rcpv_pkg::*;

	localparam logic signed [CW+2:0] SMAX = (CW+3)'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [CW+2:0] SMIN = -(CW+3)'(64'sd1 <<< (CW-1));

	logic ce;
	assign ce = !(out_valid && out_stall);
	assign in_stall = !ce;

	// stage 1: register the word, form right and bottom
	logic                 v_s1;
	in_word_t             w_s1;
	logic signed [CW:0]   right_s1, bottom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ce) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			w_s1      <= in_data;
			right_s1  <= {in_data.rect_left[CW-1], in_data.rect_left} + {2'b00, in_data.rect_width};
			bottom_s1 <= {in_data.rect_top[CW-1], in_data.rect_top} + {2'b00, in_data.rect_height};
		end
	end

	// stage 2: distance to the clamped point, edge penetrations
	logic signed [CW:0]   cx1, cy1, l1, t1;
	logic signed [CW+1:0] cx2, cy2, l2, t2, r2e, rt2, b2;
	logic                 ltx, gtx, lty, gty;
	logic [CW:0]          ax_c, ay_c;

	always_comb begin
		cx1 = {w_s1.center_x[CW-1], w_s1.center_x};
		cy1 = {w_s1.center_y[CW-1], w_s1.center_y};
		l1  = {w_s1.rect_left[CW-1], w_s1.rect_left};
		t1  = {w_s1.rect_top[CW-1], w_s1.rect_top};
		ltx = cx1 < l1;
		gtx = cx1 > right_s1;
		lty = cy1 < t1;
		gty = cy1 > bottom_s1;
		if (ltx) ax_c = l1 - cx1;
		else if (gtx) ax_c = cx1 - right_s1;
		else ax_c = '0;
		if (lty) ay_c = t1 - cy1;
		else if (gty) ay_c = cy1 - bottom_s1;
		else ay_c = '0;
		cx2 = {cx1[CW], cx1};
		cy2 = {cy1[CW], cy1};
		l2  = {l1[CW], l1};
		t2  = {t1[CW], t1};
		rt2 = {right_s1[CW], right_s1};
		b2  = {bottom_s1[CW], bottom_s1};
		r2e = {3'b000, w_s1.radius};
	end

	logic                 v_s2, negx_s2, negy_s2, flip_s2;
	logic [CW:0]          ax_s2, ay_s2;
	logic [CW-2:0]        r_s2;
	logic signed [CW+1:0] lp_s2, rp_s2, tp_s2, bp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ce) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			negx_s2 <= ltx;
			negy_s2 <= lty;
			flip_s2 <= w_s1.circle_first;
			ax_s2   <= ax_c;
			ay_s2   <= ay_c;
			r_s2    <= w_s1.radius;
			lp_s2   <= cx2 - l2 + r2e;
			rp_s2   <= rt2 - cx2 + r2e;
			tp_s2   <= cy2 - t2 + r2e;
			bp_s2   <= b2 - cy2 + r2e;
		end
	end

	// stage 3: squares, least-penetration edge (ties left, right, top, bottom)
	logic signed [CW+1:0] pxi_c, pyi_c;

	always_comb begin
		pxi_c = '0;
		pyi_c = '0;
		if (lp_s2 <= rp_s2 && lp_s2 <= tp_s2 && lp_s2 <= bp_s2) pxi_c = lp_s2;
		else if (rp_s2 <= tp_s2 && rp_s2 <= bp_s2) pxi_c = -rp_s2;
		else if (tp_s2 <= bp_s2) pyi_c = tp_s2;
		else pyi_c = -bp_s2;
	end

	logic                 v_s3;
	logic [2*CW+1:0]      sqx_s3, sqy_s3;
	logic [2*CW-3:0]      r2_s3;
	side_t                sd_s3;
	opnd_t                op_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (ce) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sqx_s3        <= ax_s2 * ax_s2;
			sqy_s3        <= ay_s2 * ay_s2;
			r2_s3         <= r_s2 * r_s2;
			sd_s3.hit     <= 1'b0;
			sd_s3.in_rect <= 1'b0;
			sd_s3.flip    <= flip_s2;
			sd_s3.negx    <= negx_s2;
			sd_s3.negy    <= negy_s2;
			sd_s3.px_i    <= pxi_c;
			sd_s3.py_i    <= pyi_c;
			op_s3.r       <= r_s2;
			op_s3.ax      <= ax_s2[RW-1:0];
			op_s3.ay      <= ay_s2[RW-1:0];
		end
	end

	// stage 4: squared distance, hit test, root seed
	logic [2*CW+2:0] dsq_c;
	side_t           sd_c;

	always_comb begin
		dsq_c        = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		sd_c         = sd_s3;
		sd_c.hit     = dsq_c < {5'b00000, r2_s3};
		sd_c.in_rect = dsq_c == '0;
	end

	// square root, one result bit per stage; index 0 is the seed
	logic            sq_v_s   [0:RW];
	logic [RW+1:0]   sq_rem_s [0:RW];
	logic [RW-1:0]   sq_root_s[0:RW];
	logic [2*RW-1:0] sq_val_s [0:RW];
	side_t           sq_sd_s  [0:RW];
	opnd_t           sq_op_s  [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (ce) sq_v_s[0] <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_val_s[0]  <= dsq_c[2*RW-1:0];
			sq_sd_s[0]   <= sd_c;
			sq_op_s[0]   <= op_s3;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+1:0] trem, trial;
		logic          ge;
		always_comb begin
			trem  = {sq_rem_s[k][RW-1:0], sq_val_s[k][2*RW-1 -: 2]};
			trial = {1'b0, sq_root_s[k][RW-2:0], 2'b01};
			ge    = trem >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (ce) sq_v_s[k+1] <= sq_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				sq_rem_s[k+1]  <= ge ? trem - trial : trem;
				sq_root_s[k+1] <= {sq_root_s[k][RW-2:0], ge};
				sq_val_s[k+1]  <= {sq_val_s[k][2*RW-3:0], 2'b00};
				sq_sd_s[k+1]   <= sq_sd_s[k];
				sq_op_s[k+1]   <= sq_op_s[k];
			end
		end
	end

	// depth = radius - floor sqrt
	logic          v_d1;
	logic [RW-1:0] depth_d1, dist_d1, ax_d1, ay_d1;
	side_t         sd_d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d1 <= 1'b0;
		else if (ce) v_d1 <= sq_v_s[RW];
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			depth_d1 <= sq_op_s[RW].r - sq_root_s[RW];
			dist_d1  <= sq_root_s[RW];
			ax_d1    <= sq_op_s[RW].ax;
			ay_d1    <= sq_op_s[RW].ay;
			sd_d1    <= sq_sd_s[RW];
		end
	end

	// products |d| * depth feed the dividers; index 0 is the seed
	logic [2*RW-1:0] nx_c, ny_c;
	assign nx_c = ax_d1 * depth_d1;
	assign ny_c = ay_d1 * depth_d1;

	logic          dv_v_s   [0:RW];
	logic [RW:0]   dvx_rem_s[0:RW], dvy_rem_s[0:RW];
	logic [RW-1:0] dvx_lo_s [0:RW], dvy_lo_s [0:RW];
	logic [RW-1:0] qx_s     [0:RW], qy_s     [0:RW];
	logic [RW-1:0] dist_s   [0:RW];
	side_t         dv_sd_s  [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (ce) dv_v_s[0] <= v_d1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			// quotient stays below 2^RW, so the top half is already below the divisor
			dvx_rem_s[0] <= {1'b0, nx_c[2*RW-1:RW]};
			dvy_rem_s[0] <= {1'b0, ny_c[2*RW-1:RW]};
			dvx_lo_s[0]  <= nx_c[RW-1:0];
			dvy_lo_s[0]  <= ny_c[RW-1:0];
			qx_s[0]      <= '0;
			qy_s[0]      <= '0;
			dist_s[0]    <= dist_d1;
			dv_sd_s[0]   <= sd_d1;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_div
		logic [RW:0] tx, ty, de;
		logic        gx, gy;
		always_comb begin
			de = {1'b0, dist_s[k]};
			tx = {dvx_rem_s[k][RW-1:0], dvx_lo_s[k][RW-1]};
			ty = {dvy_rem_s[k][RW-1:0], dvy_lo_s[k][RW-1]};
			gx = tx >= de;
			gy = ty >= de;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (ce) dv_v_s[k+1] <= dv_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				dvx_rem_s[k+1] <= gx ? tx - de : tx;
				dvy_rem_s[k+1] <= gy ? ty - de : ty;
				dvx_lo_s[k+1]  <= {dvx_lo_s[k][RW-2:0], 1'b0};
				dvy_lo_s[k+1]  <= {dvy_lo_s[k][RW-2:0], 1'b0};
				qx_s[k+1]      <= {qx_s[k][RW-2:0], gx};
				qy_s[k+1]      <= {qy_s[k][RW-2:0], gy};
				dist_s[k+1]    <= dist_s[k];
				dv_sd_s[k+1]   <= dv_sd_s[k];
			end
		end
	end

	// sign, flip and saturate into the output register
	function automatic logic signed [CW-1:0] sat(input logic signed [CW+2:0] v);
		logic signed [CW+2:0] c;
		begin
			if (v > SMAX) c = SMAX;
			else if (v < SMIN) c = SMIN;
			else c = v;
			sat = c[CW-1:0];
		end
	endfunction

	side_t                sd_f;
	logic signed [CW+1:0] qxe, qye, bx, by;
	logic signed [CW+2:0] fx, fy;
	out_word_t            ow_c;

	always_comb begin
		sd_f = dv_sd_s[RW];
		qxe  = {3'b000, qx_s[RW]};
		qye  = {3'b000, qy_s[RW]};
		if (sd_f.in_rect) begin
			bx = sd_f.px_i;
			by = sd_f.py_i;
		end else begin
			bx = sd_f.negx ? qxe : -qxe;
			by = sd_f.negy ? qye : -qye;
		end
		fx = {bx[CW+1], bx};
		fy = {by[CW+1], by};
		if (sd_f.flip) begin
			fx = -fx;
			fy = -fy;
		end
		ow_c.hit    = sd_f.hit;
		ow_c.push_x = sd_f.hit ? sat(fx) : '0;
		ow_c.push_y = sd_f.hit ? sat(fy) : '0;
	end

	logic      out_v_q;
	out_word_t out_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (ce) out_v_q <= dv_v_s[RW];
	end
	always_ff @(posedge clk) begin
		if (ce) out_w_q <= ow_c;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_w_q;

endmodule
